[rtl/core/u8sd_pkg.sv]
// Package for the UTF-8 stream decoder: transfer types and code point constants.
// Used by u8sd_decode and utf8_stream_decoder; no dependencies.
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int CP_W   = 21;
    localparam int USED_W = 3;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_CP_2       = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP_3       = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP_4       = 21'h010000;

    localparam logic [7:0] LEAD_MAX   = 8'hF4;
    localparam logic [7:0] LEAD_4_MIN = 8'hF0;
    localparam logic [7:0] LEAD_3_MIN = 8'hE0;
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic              well_formed;
        logic [USED_W-1:0] bytes_used;
        logic              last_of_run;
    } out_item_t;

endpackage

[rtl/core/u8sd_decode.sv]
// Sequence state and per-byte decode: yields up to two results per accepted byte.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  u8sd_pkg::in_item_t   item,
    output logic [1:0]           res_count,
    output u8sd_pkg::out_item_t  res0,
    output u8sd_pkg::out_item_t  res1
);
    import u8sd_pkg::*;

    logic [CP_W-1:0] acc_reg, acc_next;
    logic [1:0]      rem_reg, rem_next;
    logic [2:0]      len_reg, len_next;

    // lead decode of the current byte, from idle
    logic            lead_emit;
    out_item_t       lead_res;
    logic [CP_W-1:0] lead_acc;
    logic [1:0]      lead_rem;
    logic [2:0]      lead_len;

    logic            cont;
    logic [CP_W-1:0] acc_sh;
    logic [1:0]      rem_dec;
    logic            bad;
    logic [7:0]      b;
    logic            eos;

    assign b    = item.in_byte;
    assign eos  = item.end_of_stream;
    assign cont = (b[7:6] == CONT_TAG);

    always_comb begin
        lead_emit = 1'b0;
        lead_res  = '{code_point: REPLACEMENT_CP, well_formed: 1'b0,
                      bytes_used: USED_W'(1), last_of_run: 1'b1};
        lead_acc  = '0;
        lead_rem  = '0;
        lead_len  = '0;
        if (b <= ASCII_MAX) begin
            lead_emit           = 1'b1;
            lead_res.code_point = CP_W'(b);
            lead_res.well_formed = 1'b1;
        end else if (b > LEAD_MAX || cont) begin
            lead_emit = 1'b1;
        end else if (eos) begin
            // start cut off at once by end of stream
            lead_emit = 1'b1;
        end else if (b >= LEAD_4_MIN) begin
            lead_len = 3'd4;
            lead_rem = 2'd3;
            lead_acc = CP_W'(b[2:0]);
        end else if (b >= LEAD_3_MIN) begin
            lead_len = 3'd3;
            lead_rem = 2'd2;
            lead_acc = CP_W'(b[3:0]);
        end else begin
            lead_len = 3'd2;
            lead_rem = 2'd1;
            lead_acc = CP_W'(b[4:0]);
        end
    end

    assign acc_sh  = {acc_reg[CP_W-7:0], b[5:0]};
    assign rem_dec = rem_reg - 2'd1;

    always_comb begin
        bad = ((len_reg == 3'd2) && (acc_sh < MIN_CP_2)) ||
              ((len_reg == 3'd3) && (acc_sh < MIN_CP_3)) ||
              ((len_reg == 3'd4) && (acc_sh < MIN_CP_4)) ||
              ((acc_sh >= SURR_LO) && (acc_sh <= SURR_HI)) ||
              (acc_sh > MAX_CP);
    end

    always_comb begin
        res_count = 2'd0;
        res0      = lead_res;
        res1      = lead_res;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        if (rem_reg == 2'd0) begin
            res_count = lead_emit ? 2'd1 : 2'd0;
            acc_next  = lead_acc;
            rem_next  = lead_rem;
            len_next  = lead_len;
        end else if (cont) begin
            acc_next = acc_sh;
            rem_next = rem_dec;
            if (rem_dec == 2'd0) begin
                res_count        = 2'd1;
                res0.code_point  = bad ? REPLACEMENT_CP : acc_sh;
                res0.well_formed = !bad;
                res0.bytes_used  = len_reg;
                acc_next         = '0;
                len_next         = '0;
            end else if (eos) begin
                res_count        = 2'd1;
                res0.code_point  = REPLACEMENT_CP;
                res0.well_formed = 1'b0;
                res0.bytes_used  = len_reg - {1'b0, rem_dec};
                acc_next         = '0;
                rem_next         = '0;
                len_next         = '0;
            end
        end else begin
            // broken sequence: flush, then decode this byte as a new lead
            res0.code_point  = REPLACEMENT_CP;
            res0.well_formed = 1'b0;
            res0.bytes_used  = len_reg - {1'b0, rem_reg};
            res0.last_of_run = !lead_emit;
            res_count        = lead_emit ? 2'd2 : 2'd1;
            acc_next         = lead_acc;
            rem_next         = lead_rem;
            len_next         = lead_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            rem_reg <= '0;
            len_reg <= '0;
        end else if (take) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            len_reg <= len_next;
        end
    end

endmodule

[rtl/core/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder: byte decode plus a three-entry result queue.
// Depends on u8sd_pkg and u8sd_decode.
`timescale 1ns / 1ps

// Accepts one byte per cycle while s_ready is high and returns one code point
// per cycle while m_ready is high. Most bytes yield zero or one result. A byte
// that breaks an open sequence can yield two: the U+FFFD for the broken
// sequence, then the result of the byte as a new lead. The two results leave
// in that order. Results sit in a three-entry queue. s_ready is high while the
// queue holds at most one result, so a byte is taken even while a result waits
// at m_data. The input pauses after a byte that leaves two results, until the
// queue holds at most one result again. last_of_run marks the final result
// caused by one byte. A result reaches m_valid in the cycle after its byte
// transfer when the queue is empty, and later when it waits behind earlier results.
module utf8_stream_decoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  u8sd_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output u8sd_pkg::out_item_t  m_data
);
    import u8sd_pkg::*;

    localparam int QD = 3;

    out_item_t  q_reg [QD];
    out_item_t  q_next [QD];
    logic [1:0] cnt_reg, cnt_next;

    logic       take;
    logic       pop;
    logic [1:0] base;
    logic [1:0] res_count;
    out_item_t  res0, res1;

    assign s_ready = (cnt_reg <= 2'd1);
    assign take    = s_valid && s_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = q_reg[0];
    assign pop     = m_valid && m_ready;
    assign base    = cnt_reg - {1'b0, pop};

    u8sd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .item      (s_data),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    always_comb begin
        for (int i = 0; i < QD; i++) begin
            if (pop && (i < QD - 1)) begin
                q_next[i] = q_reg[i+1];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (take && (res_count != 2'd0) && (base == 2'(i))) begin
                q_next[i] = res0;
            end
            if (take && (res_count == 2'd2) && ((base + 2'd1) == 2'(i))) begin
                q_next[i] = res1;
            end
        end
        cnt_next = base + (take ? res_count : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QD; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

[bench/utf8_stream_decoder_tb.sv]
// Self-checking testbench for utf8_stream_decoder: directed byte table, then random UTF-8 traffic.
// Depends on u8sd_pkg and the utf8_stream_decoder RTL; predicts each code point in-bench.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
    import u8sd_pkg::*;

    localparam int PREDICT      = -1;
    localparam int RANDOM_BYTES = 800;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int PRINT_CAP    = 50;

    typedef struct {
        logic [7:0] data;
        logic       eos;
        logic       known;
        int         count;
        out_item_t  res [2];
    } step_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    logic [CP_W-1:0] acc_bits;
    logic [1:0]      conts_left;
    logic [2:0]      seq_len;

    out_item_t step_results [$];
    out_item_t expected_cps [$];
    step_row_t directed_rows [$];
    step_row_t cur_row;

    int  errs;
    int  bytes_sent;
    int  results_checked;
    int  malformed_seen;
    bit  calm;
    bit  hold_req;

    utf8_stream_decoder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic report_mismatch(string msg);
        if (errs < PRINT_CAP) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        errs++;
    endtask

    function automatic void emit_cp(logic [CP_W-1:0] cp, logic ok, logic [USED_W-1:0] used);
        out_item_t r;
        r.code_point  = cp;
        r.well_formed = ok;
        r.bytes_used  = used;
        r.last_of_run = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void go_idle();
        acc_bits   = '0;
        conts_left = '0;
        seq_len    = '0;
    endfunction

    function automatic void open_sequence(logic [7:0] b, logic eos);
        if (b <= ASCII_MAX) begin
            emit_cp({13'b0, b}, 1'b1, 3'd1);
        end else if (b > LEAD_MAX || b[7:6] == CONT_TAG) begin
            emit_cp(REPLACEMENT_CP, 1'b0, 3'd1);
        end else begin
            if (b >= LEAD_4_MIN) begin
                seq_len  = 3'd4;
                acc_bits = {18'b0, b[2:0]};
            end else if (b >= LEAD_3_MIN) begin
                seq_len  = 3'd3;
                acc_bits = {17'b0, b[3:0]};
            end else begin
                seq_len  = 3'd2;
                acc_bits = {16'b0, b[4:0]};
            end
            conts_left = 2'(seq_len - 3'd1);
            if (eos) begin
                go_idle();
                emit_cp(REPLACEMENT_CP, 1'b0, 3'd1);
            end
        end
    endfunction

    function automatic void decode_byte(in_item_t it);
        logic [7:0]        b;
        logic [CP_W-1:0]   c;
        logic [USED_W-1:0] used;
        logic              bad;
        out_item_t         tail;
        b = it.in_byte;
        step_results.delete();
        if (conts_left == 2'd0) begin
            open_sequence(b, it.end_of_stream);
        end else if (b[7:6] == CONT_TAG) begin
            acc_bits   = {acc_bits[CP_W-7:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left == 2'd0) begin
                c    = acc_bits;
                used = seq_len;
                bad  = (used == 3'd2 && c < MIN_CP_2) || (used == 3'd3 && c < MIN_CP_3) ||
                       (used == 3'd4 && c < MIN_CP_4) || (c >= SURR_LO && c <= SURR_HI) ||
                       (c > MAX_CP);
                go_idle();
                emit_cp(bad ? REPLACEMENT_CP : c, !bad, used);
            end else if (it.end_of_stream) begin
                used = seq_len - {1'b0, conts_left};
                go_idle();
                emit_cp(REPLACEMENT_CP, 1'b0, used);
            end
        end else begin
            used = seq_len - {1'b0, conts_left};
            go_idle();
            emit_cp(REPLACEMENT_CP, 1'b0, used);
            open_sequence(b, it.end_of_stream);
        end
        if (step_results.size() > 0) begin
            tail = step_results.pop_back();
            tail.last_of_run = 1'b1;
            step_results.push_back(tail);
        end
    endfunction

    task automatic check_result(out_item_t got);
        out_item_t want;
        results_checked++;
        if (!got.well_formed) begin
            malformed_seen++;
        end
        if (expected_cps.size() == 0) begin
            report_mismatch($sformatf("unexpected code point %06h", got.code_point));
            return;
        end
        want = expected_cps.pop_front();
        if (got.code_point !== want.code_point) begin
            report_mismatch($sformatf("code_point got %06h want %06h",
                                      got.code_point, want.code_point));
        end
        if (got.well_formed !== want.well_formed) begin
            report_mismatch($sformatf("well_formed got %0b want %0b (cp %06h)",
                                      got.well_formed, want.well_formed, want.code_point));
        end
        if (got.bytes_used !== want.bytes_used) begin
            report_mismatch($sformatf("bytes_used got %0d want %0d (cp %06h)",
                                      got.bytes_used, want.bytes_used, want.code_point));
        end
        if (got.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf("last_of_run got %0b want %0b (cp %06h)",
                                      got.last_of_run, want.last_of_run, want.code_point));
        end
    endtask

    // Results leave no earlier than the cycle after their byte, so check before predicting.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data);
                if (cur_row.known) begin
                    for (int i = 0; i < cur_row.count; i++) begin
                        expected_cps.push_back(cur_row.res[i]);
                    end
                end else begin
                    foreach (step_results[i]) begin
                        expected_cps.push_back(step_results[i]);
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 96) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    task automatic add_row(logic [7:0] b, logic eos, int count,
                           logic [CP_W-1:0] cp0 = '0, logic ok0 = 1'b0, int used0 = 0,
                           logic [CP_W-1:0] cp1 = '0, logic ok1 = 1'b0, int used1 = 0);
        step_row_t r;
        r.data  = b;
        r.eos   = eos;
        r.known = (count != PREDICT);
        r.count = (count == PREDICT) ? 0 : count;
        r.res[0] = '{code_point: cp0, well_formed: ok0, bytes_used: USED_W'(used0),
                     last_of_run: (count == 1)};
        r.res[1] = '{code_point: cp1, well_formed: ok1, bytes_used: USED_W'(used1),
                     last_of_run: 1'b1};
        directed_rows.push_back(r);
    endtask

    task automatic send_step(step_row_t row, int gap);
        for (int i = 0; i < gap; i++) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        cur_row = row;
        s_data  = '{in_byte: row.data, end_of_stream: row.eos};
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Mostly well-formed sequences with random content; the rest is noise, overlong forms,
    // surrogates, out-of-range values, cut-off sequences and early end of stream.
    task automatic send_random_sequence();
        logic [7:0]      seq [4];
        logic [CP_W-1:0] cp;
        int              len;
        int              roll;
        int              sel;
        int              eos_at;
        step_row_t       r;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            len    = 1;
            seq[0] = 8'($urandom_range(0, 255));
        end else begin
            len = $urandom_range(1, 4);
            sel = $urandom_range(0, 99);
            case (len)
                1:       cp = CP_W'($urandom_range(0, 32'h7F));
                2:       cp = CP_W'($urandom_range(MIN_CP_2, MIN_CP_3 - 1));
                3:       cp = CP_W'($urandom_range(MIN_CP_3, MIN_CP_4 - 1));
                default: cp = CP_W'($urandom_range(MIN_CP_4, MAX_CP));
            endcase
            if (sel < 8 && len > 1) begin
                case (len)
                    2:       cp = CP_W'($urandom_range(0, MIN_CP_2 - 1));
                    3:       cp = CP_W'($urandom_range(0, MIN_CP_3 - 1));
                    default: cp = CP_W'($urandom_range(0, MIN_CP_4 - 1));
                endcase
            end else if (sel >= 8 && sel < 14) begin
                len = 3;
                cp  = CP_W'($urandom_range(SURR_LO, SURR_HI));
            end else if (sel >= 14 && sel < 20) begin
                len = 4;
                cp  = CP_W'($urandom_range(MAX_CP + 1, 32'h1FFFFF));
            end
            case (len)
                1: begin
                    seq[0] = {1'b0, cp[6:0]};
                end
                2: begin
                    seq[0] = {3'b110, cp[10:6]};
                    seq[1] = {CONT_TAG, cp[5:0]};
                end
                3: begin
                    seq[0] = {4'b1110, cp[15:12]};
                    seq[1] = {CONT_TAG, cp[11:6]};
                    seq[2] = {CONT_TAG, cp[5:0]};
                end
                default: begin
                    seq[0] = {5'b11110, cp[20:18]};
                    seq[1] = {CONT_TAG, cp[17:12]};
                    seq[2] = {CONT_TAG, cp[11:6]};
                    seq[3] = {CONT_TAG, cp[5:0]};
                end
            endcase
            if (len > 1 && $urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, len - 1);
            end
        end
        eos_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            r.data  = seq[i];
            r.eos   = (i == eos_at);
            r.known = 1'b0;
            r.count = 0;
            send_step(r, (calm || hold_req) ? 0 : pick_gap());
        end
    endtask

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                m_ready = 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    @(negedge aclk);
                end
                hold_req = 1'b0;
            end else if (calm) begin
                m_ready = 1'b1;
                @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
                begin
                    int gap;
                    gap = pick_gap();
                    if (gap > 0) begin
                        m_ready = 1'b0;
                        repeat (gap) @(negedge aclk);
                    end
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d code points outstanding", expected_cps.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        cur_row  = '{default: '0};
        calm     = 1'b0;
        hold_req = 1'b0;
        errs            = 0;
        bytes_sent      = 0;
        results_checked = 0;
        malformed_seen  = 0;
        go_idle();

        // ASCII extremes, stray continuation, bad leads
        add_row(8'h00, 1'b0, 1, 21'h000000, 1'b1, 1);
        add_row(8'h7F, 1'b1, 1, 21'h00007F, 1'b1, 1);
        add_row(8'h80, 1'b0, 1, REPLACEMENT_CP, 1'b0, 1);
        add_row(8'hF5, 1'b0, 1, REPLACEMENT_CP, 1'b0, 1);
        add_row(8'hFF, 1'b0, 1, REPLACEMENT_CP, 1'b0, 1);
        // overlong two-byte NUL
        add_row(8'hC0, 1'b0, PREDICT);
        add_row(8'h80, 1'b0, 1, REPLACEMENT_CP, 1'b0, 2);
        // first surrogate
        add_row(8'hED, 1'b0, PREDICT);
        add_row(8'hA0, 1'b0, PREDICT);
        add_row(8'h80, 1'b0, 1, REPLACEMENT_CP, 1'b0, 3);
        // largest scalar value
        add_row(8'hF4, 1'b0, PREDICT);
        add_row(8'h8F, 1'b0, PREDICT);
        add_row(8'hBF, 1'b0, PREDICT);
        add_row(8'hBF, 1'b0, 1, MAX_CP, 1'b1, 4);
        // one past the largest
        add_row(8'hF4, 1'b0, PREDICT);
        add_row(8'h90, 1'b0, PREDICT);
        add_row(8'h80, 1'b0, PREDICT);
        add_row(8'h80, 1'b0, 1, REPLACEMENT_CP, 1'b0, 4);
        // broken by ASCII, which is then decoded as a new lead
        add_row(8'hF0, 1'b0, PREDICT);
        add_row(8'h9F, 1'b0, PREDICT);
        add_row(8'h41, 1'b0, 2, REPLACEMENT_CP, 1'b0, 2, 21'h000041, 1'b1, 1);
        // lead carrying end of stream, and a cut-off three-byte form
        add_row(8'hC3, 1'b1, 1, REPLACEMENT_CP, 1'b0, 1);
        add_row(8'hE2, 1'b0, PREDICT);
        add_row(8'h82, 1'b1, 1, REPLACEMENT_CP, 1'b0, 2);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            send_step(directed_rows[i], pick_gap());
        end

        // Stall the output while bytes keep coming so the result queue fills up.
        hold_req = 1'b1;
        while (bytes_sent < directed_rows.size() + RANDOM_BYTES) begin
            calm = (bytes_sent >= 400 && bytes_sent < 480);
            send_random_sequence();
        end
        calm = 1'b0;
        @(negedge aclk);
        s_valid = 1'b0;

        while (expected_cps.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Drove %0d bytes: directed edge cases plus random UTF-8 with breaks and gaps",
                 bytes_sent);
        $display("Checked %0d code points (%0d replacements), %0d mismatches",
                 results_checked, malformed_seen, errs);
        if (errs == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
